/* rtl/drsp_pkg.sv */
package drsp_pkg;

    // fixed field widths
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned COLUMN_W = 4;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned INDEX_W  = 8;
    localparam int unsigned CFG_IDX_W = 1;

    // default limits
    localparam int unsigned MAX_COLS_DEF = 16;
    localparam int unsigned MAX_ROWS_DEF = 16;

    // reset values of the count registers
    localparam logic [COUNT_W-1:0] ROW_COUNT_RST    = 5'd4;
    localparam logic [COUNT_W-1:0] COLUMN_COUNT_RST = 5'd4;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT    = 1'b0,
        CFG_COLUMN_COUNT = 1'b1
    } t_cfg_idx;

    // control state
    typedef enum logic [1:0] {
        ST_FILL = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    // one row buffer entry
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [COLUMN_W-1:0] column;
    } t_store_entry;

    // clamp a count register to 1..limit
    function automatic logic [COUNT_W-1:0] eff_count(
        input logic [COUNT_W-1:0] cnt,
        input logic [COUNT_W-1:0] limit
    );
        logic [COUNT_W-1:0] res;
        if (cnt == '0) begin
            res = 5'd1;
        end else if (cnt > limit) begin
            res = limit;
        end else begin
            res = cnt;
        end
        return res;
    endfunction

endpackage

/* rtl/drsp_elem_if.sv */
interface drsp_elem_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [drsp_pkg::VALUE_W-1:0]  element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

/* rtl/drsp_nz_if.sv */
interface drsp_nz_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [drsp_pkg::VALUE_W-1:0]  nonzero_value;
    logic [drsp_pkg::COLUMN_W-1:0]        column_index;
    logic [drsp_pkg::COUNT_W-1:0]         row_length;
    logic [drsp_pkg::INDEX_W-1:0]         nonzero_index;
    logic                                 last_of_row;

    modport source (output valid, output nonzero_value, output column_index,
                    output row_length, output nonzero_index, output last_of_row,
                    input ready);
    modport sink   (input valid, input nonzero_value, input column_index,
                    input row_length, input nonzero_index, input last_of_row,
                    output ready);
endinterface

/* rtl/drsp_row_buf.sv */
module drsp_row_buf #(
    parameter int unsigned DEPTH = drsp_pkg::MAX_COLS_DEF,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  drsp_pkg::t_store_entry i_wdata,
    input  logic                   i_re,
    input  logic [AW-1:0]          i_raddr,
    output drsp_pkg::t_store_entry o_rdata
);

    drsp_pkg::t_store_entry r_mem [DEPTH];
    drsp_pkg::t_store_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/dense_row_to_sparse_packer.sv */
// channel   dir  beat payload                                             
// i_elem    in   element_value (s32)                                      
// o_nz      out  nonzero_value (s32), column_index (4), row_length (5),
//                nonzero_index (8), last_of_row (1)
// cfg       in   i_cfg_we, i_cfg_idx (0 row_count, 1 column_count), i_cfg_data (5)
//
// one element beat is taken per cycle while a row fills; after the last column
// a row with N nonzeros is read out of the row buffer, one entry per cycle while
// the output is not stalled, through the single read port of the buffer. intake
// resumes once the last read is issued.
// reset is synchronous, active low; no clearing pass. a stalled output beat
// holds in the output register and stops further reads.
module dense_row_to_sparse_packer #(
    parameter int unsigned MAX_COLS = drsp_pkg::MAX_COLS_DEF,
    parameter int unsigned MAX_ROWS = drsp_pkg::MAX_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    drsp_elem_if.sink                         i_elem,
    drsp_nz_if.source                         o_nz,
    input  logic                              i_cfg_we,
    input  logic [drsp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [drsp_pkg::COUNT_W-1:0]      i_cfg_data
);

    localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic [drsp_pkg::COUNT_W-1:0] COL_LIM =
        (MAX_COLS > 31) ? 5'd31 : 5'(MAX_COLS);
    localparam logic [drsp_pkg::COUNT_W-1:0] ROW_LIM =
        (MAX_ROWS > 31) ? 5'd31 : 5'(MAX_ROWS);
    localparam logic [6:0] ROW_CAP = 7'(MAX_COLS);

    drsp_pkg::t_state               r_state, n_state;
    logic [drsp_pkg::COUNT_W-1:0]   r_row_count, r_col_count;
    logic [drsp_pkg::COUNT_W-1:0]   r_col_pos, n_col_pos;
    logic [drsp_pkg::COUNT_W-1:0]   r_row_pos, n_row_pos;
    logic [drsp_pkg::COUNT_W-1:0]   r_row_nz, n_row_nz;
    logic [drsp_pkg::INDEX_W-1:0]   r_mat_nz, n_mat_nz;
    logic [drsp_pkg::COUNT_W-1:0]   r_emit_len, n_emit_len;
    logic [drsp_pkg::INDEX_W-1:0]   r_emit_base, n_emit_base;
    logic [drsp_pkg::COUNT_W-1:0]   r_rd_idx, n_rd_idx;
    logic                           r_out_vld;
    logic [drsp_pkg::COUNT_W-1:0]   r_out_len;
    logic [drsp_pkg::INDEX_W-1:0]   r_out_idx;
    logic                           r_out_last;

    logic [drsp_pkg::COUNT_W-1:0]   cols_eff, rows_eff;
    logic                           in_fire, do_wr, last_col, last_row;
    logic                           out_free, issue, last_issue;
    logic [drsp_pkg::COUNT_W-1:0]   new_nz;
    drsp_pkg::t_store_entry         wr_entry, rd_entry;

    // effective counts
    assign cols_eff = drsp_pkg::eff_count(r_col_count, COL_LIM);
    assign rows_eff = drsp_pkg::eff_count(r_row_count, ROW_LIM);

    // intake side
    assign i_elem.ready = (r_state == drsp_pkg::ST_FILL);
    assign in_fire      = i_elem.valid && i_elem.ready;
    assign do_wr        = in_fire && (i_elem.element_value != '0)
                          && ({2'b00, r_row_nz} < ROW_CAP);
    assign new_nz       = r_row_nz + (do_wr ? 5'd1 : 5'd0);
    assign last_col     = ({1'b0, r_col_pos} + 6'd1) >= {1'b0, cols_eff};
    assign last_row     = ({1'b0, r_row_pos} + 6'd1) >= {1'b0, rows_eff};

    assign wr_entry.value  = i_elem.element_value;
    assign wr_entry.column = r_col_pos[drsp_pkg::COLUMN_W-1:0];

    // emit side: a read is issued when the output register frees up
    assign out_free   = !r_out_vld || o_nz.ready;
    assign issue      = (r_state == drsp_pkg::ST_EMIT) && out_free;
    assign last_issue = (r_rd_idx + 5'd1) == r_emit_len;

    // row buffer
    drsp_row_buf #(
        .DEPTH (MAX_COLS),
        .AW    (AW)
    ) u_row_buf (
        .i_clk   (i_clk),
        .i_we    (do_wr),
        .i_waddr (AW'(r_row_nz)),
        .i_wdata (wr_entry),
        .i_re    (issue),
        .i_raddr (AW'(r_rd_idx)),
        .o_rdata (rd_entry)
    );

    // next state of counters and sequencer
    always_comb begin
        n_state     = r_state;
        n_col_pos   = r_col_pos;
        n_row_pos   = r_row_pos;
        n_row_nz    = r_row_nz;
        n_mat_nz    = r_mat_nz;
        n_emit_len  = r_emit_len;
        n_emit_base = r_emit_base;
        n_rd_idx    = r_rd_idx;

        unique case (r_state)
            drsp_pkg::ST_FILL: begin
                if (in_fire) begin
                    if (last_col) begin
                        n_emit_len  = new_nz;
                        n_emit_base = r_mat_nz;
                        n_rd_idx    = '0;
                        n_row_nz    = '0;
                        n_col_pos   = '0;
                        if (last_row) begin
                            n_row_pos = '0;
                            n_mat_nz  = '0;
                        end else begin
                            n_row_pos = r_row_pos + 5'd1;
                            n_mat_nz  = r_mat_nz + 8'(new_nz);
                        end
                        if (new_nz != '0) begin
                            n_state = drsp_pkg::ST_EMIT;
                        end
                    end else begin
                        n_row_nz  = new_nz;
                        n_col_pos = r_col_pos + 5'd1;
                    end
                end
            end
            drsp_pkg::ST_EMIT: begin
                if (issue) begin
                    n_rd_idx = r_rd_idx + 5'd1;
                    if (last_issue) begin
                        n_state = drsp_pkg::ST_FILL;
                    end
                end
            end
            default: begin
                n_state = drsp_pkg::ST_FILL;
            end
        endcase

        // a register write restarts the matrix
        if (i_cfg_we) begin
            n_state   = drsp_pkg::ST_FILL;
            n_col_pos = '0;
            n_row_pos = '0;
            n_row_nz  = '0;
            n_mat_nz  = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= drsp_pkg::ST_FILL;
            r_col_pos <= '0;
            r_row_pos <= '0;
            r_row_nz  <= '0;
            r_mat_nz  <= '0;
            r_rd_idx  <= '0;
        end else begin
            r_state   <= n_state;
            r_col_pos <= n_col_pos;
            r_row_pos <= n_row_pos;
            r_row_nz  <= n_row_nz;
            r_mat_nz  <= n_mat_nz;
            r_rd_idx  <= n_rd_idx;
        end
    end

    // row readout length and base
    always_ff @(posedge i_clk) begin
        r_emit_len  <= n_emit_len;
        r_emit_base <= n_emit_base;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= drsp_pkg::ROW_COUNT_RST;
            r_col_count <= drsp_pkg::COLUMN_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (drsp_pkg::t_cfg_idx'(i_cfg_idx))
                drsp_pkg::CFG_ROW_COUNT:    r_row_count <= i_cfg_data;
                drsp_pkg::CFG_COLUMN_COUNT: r_col_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (issue) begin
            r_out_vld <= 1'b1;
        end else if (o_nz.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // output beat sideband, loaded alongside the buffer read
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_out_len  <= r_emit_len;
            r_out_idx  <= r_emit_base + 8'(r_rd_idx);
            r_out_last <= last_issue;
        end
    end

    assign o_nz.valid         = r_out_vld;
    assign o_nz.nonzero_value = rd_entry.value;
    assign o_nz.column_index  = rd_entry.column;
    assign o_nz.row_length    = r_out_len;
    assign o_nz.nonzero_index = r_out_idx;
    assign o_nz.last_of_row   = r_out_last;

endmodule
